// ===== src/vram_first_fit_allocator_defines.svh =====
// Assertion macros used by the checker file.
`ifndef VRAM_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define VRAM_FIRST_FIT_ALLOCATOR_DEFINES_SVH

`define VFFA_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("vffa assertion failed");

`define VFFA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("vffa assertion failed");

`endif

// ===== src/vffa_pkg.sv =====
package vffa_pkg;

  localparam int LIVE_ENTRIES = 64;
  localparam int FREE_ENTRIES = 65;
  localparam int ADDR_BITS    = 40;
  localparam int LEN_BITS     = ADDR_BITS + 1;
  localparam int ALIGN_BITS   = 17;
  localparam int LIVE_IDX_W   = $clog2(LIVE_ENTRIES);
  localparam int FREE_IDX_W   = $clog2(FREE_ENTRIES);
  localparam int SCAN_W       = $clog2(FREE_ENTRIES + 1);
  localparam int ENTRY_W      = ADDR_BITS + LEN_BITS;
  localparam int DIV_CNT_W    = $clog2(ADDR_BITS + 1);
  localparam int FUNC_BITS    = 2;
  localparam int STAT_BITS    = 3;
  localparam int IN_RAW_W     = FUNC_BITS + 2 * ADDR_BITS + LEN_BITS;
  localparam int IN_DATA_W    = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W    = STAT_BITS + ADDR_BITS + 2 * LEN_BITS;
  localparam int OUT_DATA_W   = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = LEN_BITS;

  localparam logic [LEN_BITS-1:0]   TOTAL_RESET = LEN_BITS'(268435456);
  localparam logic [ALIGN_BITS-1:0] ALIGN_RESET = ALIGN_BITS'(256);
  localparam logic [LEN_BITS-1:0]   TOTAL_CAP   = {1'b1, {ADDR_BITS{1'b0}}};

  typedef enum logic [FUNC_BITS-1:0] {
    FN_ALLOC, FN_FREE, FN_CHECK, FN_NONE
  } func_t;

  typedef enum logic [STAT_BITS-1:0] {
    STAT_OK, STAT_ZERO, STAT_NOFIT, STAT_FULL, STAT_NOTLIVE, STAT_NOTOWNED
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_SIZE, REG_ALIGNMENT
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_FSCAN, S_AWRITE, S_LSCAN, S_MSCAN, S_MWRITE, S_CSCAN, S_DONE
  } state_t;

endpackage

// ===== src/vram_first_fit_allocator.sv =====
// Channel  Direction  Fields (lowest bit first)
// in_      slave      func, request_bytes, address, range_length
// out_     master     status, result_address, granted_bytes, live_total
// cfg_     write      0 total_size, 1 alignment
// Allocate runs the bit-serial alignment remainder, then one pass over the 65-entry
// free memory, one read per cycle. Free makes a pass over the live memory, then one
// over the free memory; check makes one pass over the live memory.
// Reset is synchronous; live valid bits and the count clear at once, no clearing pass.
// A finished result waits in the output register while the next item is accepted.
module vram_first_fit_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // func, request_bytes, address, range_length
  input  logic [vffa_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status, result_address, granted_bytes, live_total
  output logic [vffa_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [vffa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vffa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = vffa_pkg::ADDR_BITS;
  localparam int LW = vffa_pkg::LEN_BITS;
  localparam int GW = vffa_pkg::ALIGN_BITS;
  localparam int FI = vffa_pkg::FREE_IDX_W;
  localparam int LI = vffa_pkg::LIVE_IDX_W;
  localparam int SW = vffa_pkg::SCAN_W;

  vffa_pkg::state_t  state_r, state_nxt;
  logic [LW-1:0]     ts_r, ts_nxt;
  logic [GW-1:0]     align_r, align_nxt;
  logic [vffa_pkg::FREE_ENTRIES-1:0] free_vld_r, free_vld_nxt;
  logic [vffa_pkg::LIVE_ENTRIES-1:0] live_vld_r, live_vld_nxt;
  logic              free0_init_r, free0_init_nxt;
  logic [LW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [LW-1:0]     rlen_r, rlen_nxt;
  logic [AW-1:0]     dq_r, dq_nxt;
  logic [GW-1:0]     rem_r, rem_nxt;
  logic [vffa_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [LW-1:0]     req_r, req_nxt;
  logic [LW-1:0]     need_r, need_nxt;
  logic [LI-1:0]     slot_r, slot_nxt;
  logic [SW-1:0]     scan_r, scan_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [FI-1:0]     rd_idx_r, rd_idx_nxt;
  logic              best_fnd_r, best_fnd_nxt;
  logic [FI-1:0]     best_idx_r, best_idx_nxt;
  logic [AW-1:0]     best_start_r, best_start_nxt;
  logic [LW-1:0]     best_len_r, best_len_nxt;
  logic              hit_r, hit_nxt;
  logic [LI-1:0]     hit_idx_r, hit_idx_nxt;
  logic [LW-1:0]     hit_len_r, hit_len_nxt;
  logic              succ_fnd_r, succ_fnd_nxt;
  logic [FI-1:0]     succ_idx_r, succ_idx_nxt;
  logic              pred_fnd_r, pred_fnd_nxt;
  logic [FI-1:0]     pred_idx_r, pred_idx_nxt;
  logic [AW-1:0]     pred_start_r, pred_start_nxt;
  logic [LW-1:0]     acc_len_r, acc_len_nxt;
  logic              own_r, own_nxt;
  vffa_pkg::status_t res_status_r, res_status_nxt;
  logic [AW-1:0]     res_addr_r, res_addr_nxt;
  logic [LW-1:0]     res_gr_r, res_gr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [vffa_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                         free_we, live_we;
  logic [FI-1:0]                free_waddr;
  logic [LI-1:0]                live_waddr;
  logic [vffa_pkg::ENTRY_W-1:0] free_wdata, live_wdata, free_rdata, live_rdata;

  logic [GW-1:0]   a_eff;
  logic [AW-1:0]   f_start, l_start;
  logic [LW-1:0]   f_len, l_len;
  logic [LI-1:0]   lslot;
  logic            lslot_ok;
  logic [vffa_pkg::FREE_ENTRIES-1:0] fmask;
  logic [FI-1:0]   fslot;
  logic            fslot_ok;
  logic [GW:0]     div_t;
  logic [LW-1:0]   end_addr;
  logic [AW-1:0]   off;
  logic [LW-1:0]   ts_clamp;
  logic            scan_end;
  logic [SW-1:0]   scan_lim;

  vffa_ram #(.WIDTH(vffa_pkg::ENTRY_W), .DEPTH(vffa_pkg::FREE_ENTRIES)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(scan_r[FI-1:0]), .rdata(free_rdata)
  );

  vffa_ram #(.WIDTH(vffa_pkg::ENTRY_W), .DEPTH(vffa_pkg::LIVE_ENTRIES)) u_live_ram (
    .clk(clk), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
    .raddr(scan_r[LI-1:0]), .rdata(live_rdata)
  );

  assign in_tready  = (state_r == vffa_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    a_eff = (align_r == '0) ? GW'(1) : align_r;
    if (rd_idx_r == '0 && free0_init_r) begin
      f_start = '0;
      f_len   = ts_r;
    end else begin
      f_start = free_rdata[AW-1:0];
      f_len   = free_rdata[vffa_pkg::ENTRY_W-1:AW];
    end
    l_start = live_rdata[AW-1:0];
    l_len   = live_rdata[vffa_pkg::ENTRY_W-1:AW];

    lslot    = '0;
    lslot_ok = 1'b0;
    for (int i = vffa_pkg::LIVE_ENTRIES - 1; i >= 0; i--) begin
      if (!live_vld_r[i]) begin
        lslot    = LI'(i);
        lslot_ok = 1'b1;
      end
    end

    fmask = free_vld_r;
    if (succ_fnd_r) fmask[succ_idx_r] = 1'b0;
    if (pred_fnd_r) fmask[pred_idx_r] = 1'b0;
    fslot    = '0;
    fslot_ok = 1'b0;
    for (int i = vffa_pkg::FREE_ENTRIES - 1; i >= 0; i--) begin
      if (!fmask[i]) begin
        fslot    = FI'(i);
        fslot_ok = 1'b1;
      end
    end

    div_t    = {rem_r, dq_r[AW-1]};
    end_addr = {1'b0, addr_r} + hit_len_r;
    off      = addr_r - l_start;
    ts_clamp = (cfg_wdata > vffa_pkg::TOTAL_CAP) ? vffa_pkg::TOTAL_CAP : cfg_wdata;
    scan_lim = (state_r == vffa_pkg::S_FSCAN || state_r == vffa_pkg::S_MSCAN)
             ? SW'(vffa_pkg::FREE_ENTRIES) : SW'(vffa_pkg::LIVE_ENTRIES);
    scan_end = (scan_r == scan_lim) && !rd_vld_r;
  end

  always_comb begin
    state_nxt      = state_r;
    ts_nxt         = ts_r;
    align_nxt      = align_r;
    free_vld_nxt   = free_vld_r;
    live_vld_nxt   = live_vld_r;
    free0_init_nxt = free0_init_r;
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    rlen_nxt       = rlen_r;
    req_nxt        = req_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    need_nxt       = need_r;
    slot_nxt       = slot_r;
    scan_nxt       = scan_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    best_fnd_nxt   = best_fnd_r;
    best_idx_nxt   = best_idx_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_len_nxt    = hit_len_r;
    succ_fnd_nxt   = succ_fnd_r;
    succ_idx_nxt   = succ_idx_r;
    pred_fnd_nxt   = pred_fnd_r;
    pred_idx_nxt   = pred_idx_r;
    pred_start_nxt = pred_start_r;
    acc_len_nxt    = acc_len_r;
    own_nxt        = own_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_gr_nxt     = res_gr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    free_we        = 1'b0;
    free_waddr     = best_idx_r;
    free_wdata     = '0;
    live_we        = 1'b0;
    live_waddr     = slot_r;
    live_wdata     = {need_r, best_start_r};

    if (state_r == vffa_pkg::S_FSCAN || state_r == vffa_pkg::S_LSCAN ||
        state_r == vffa_pkg::S_MSCAN || state_r == vffa_pkg::S_CSCAN) begin
      if (scan_r != scan_lim) begin
        scan_nxt   = scan_r + SW'(1);
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = scan_r[FI-1:0];
      end
    end

    unique case (state_r)
      vffa_pkg::S_IDLE: begin
        if (in_tvalid) begin
          req_nxt        = {1'b0, in_tdata[AW+1:2]};
          addr_nxt       = in_tdata[2*AW+1:AW+2];
          rlen_nxt       = in_tdata[2*AW+LW+1:2*AW+2];
          scan_nxt       = '0;
          best_fnd_nxt   = 1'b0;
          hit_nxt        = 1'b0;
          succ_fnd_nxt   = 1'b0;
          pred_fnd_nxt   = 1'b0;
          own_nxt        = 1'b0;
          res_status_nxt = vffa_pkg::STAT_OK;
          res_addr_nxt   = '0;
          res_gr_nxt     = '0;
          unique case (vffa_pkg::func_t'(in_tdata[1:0]))
            vffa_pkg::FN_ALLOC: begin
              if (in_tdata[AW+1:2] == '0) begin
                res_status_nxt = vffa_pkg::STAT_ZERO;
                state_nxt      = vffa_pkg::S_DONE;
              end else if (!lslot_ok) begin
                res_status_nxt = vffa_pkg::STAT_FULL;
                state_nxt      = vffa_pkg::S_DONE;
              end else begin
                slot_nxt    = lslot;
                dq_nxt      = in_tdata[AW+1:2];
                rem_nxt     = '0;
                div_cnt_nxt = '0;
                state_nxt   = vffa_pkg::S_DIV;
              end
            end
            vffa_pkg::FN_FREE:  state_nxt = vffa_pkg::S_LSCAN;
            vffa_pkg::FN_CHECK: state_nxt = vffa_pkg::S_CSCAN;
            default:            state_nxt = vffa_pkg::S_DONE;
          endcase
        end
      end
      vffa_pkg::S_DIV: begin
        if (div_cnt_r == vffa_pkg::DIV_CNT_W'(AW)) begin
          need_nxt  = req_r + ((rem_r == '0) ? '0 : LW'(a_eff - rem_r));
          state_nxt = vffa_pkg::S_FSCAN;
        end else begin
          rem_nxt     = (div_t >= {1'b0, a_eff}) ? GW'(div_t - {1'b0, a_eff}) : div_t[GW-1:0];
          dq_nxt      = dq_r << 1;
          div_cnt_nxt = div_cnt_r + vffa_pkg::DIV_CNT_W'(1);
        end
      end
      vffa_pkg::S_FSCAN: begin
        if (rd_vld_r && free_vld_r[rd_idx_r] && f_len >= need_r &&
            (!best_fnd_r || f_start < best_start_r)) begin
          best_fnd_nxt   = 1'b1;
          best_idx_nxt   = rd_idx_r;
          best_start_nxt = f_start;
          best_len_nxt   = f_len;
        end
        if (scan_end) begin
          if (!best_fnd_r) begin
            res_status_nxt = vffa_pkg::STAT_NOFIT;
            state_nxt      = vffa_pkg::S_DONE;
          end else begin
            state_nxt = vffa_pkg::S_AWRITE;
          end
        end
      end
      vffa_pkg::S_AWRITE: begin
        if (best_len_r == need_r) begin
          free_vld_nxt[best_idx_r] = 1'b0;
        end else begin
          free_we    = 1'b1;
          free_wdata = {LW'(best_len_r - need_r), AW'(best_start_r + need_r[AW-1:0])};
          if (best_idx_r == '0) free0_init_nxt = 1'b0;
        end
        live_we              = 1'b1;
        live_vld_nxt[slot_r] = 1'b1;
        count_nxt            = count_r + need_r;
        res_addr_nxt         = best_start_r;
        res_gr_nxt           = need_r;
        state_nxt            = vffa_pkg::S_DONE;
      end
      vffa_pkg::S_LSCAN: begin
        if (rd_vld_r && !hit_r && live_vld_r[rd_idx_r[LI-1:0]] && l_start == addr_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = rd_idx_r[LI-1:0];
          hit_len_nxt = l_len;
          acc_len_nxt = l_len;
        end
        if (scan_end) begin
          scan_nxt = '0;
          if (!hit_r) begin
            res_status_nxt = vffa_pkg::STAT_NOTLIVE;
            state_nxt      = vffa_pkg::S_DONE;
          end else begin
            state_nxt = vffa_pkg::S_MSCAN;
          end
        end
      end
      vffa_pkg::S_MSCAN: begin
        if (rd_vld_r && free_vld_r[rd_idx_r]) begin
          if (!succ_fnd_r && {1'b0, f_start} == end_addr) begin
            succ_fnd_nxt = 1'b1;
            succ_idx_nxt = rd_idx_r;
            acc_len_nxt  = acc_len_r + f_len;
          end else if (!pred_fnd_r && f_start < addr_r &&
                       ({1'b0, f_start} + f_len) == {1'b0, addr_r}) begin
            pred_fnd_nxt   = 1'b1;
            pred_idx_nxt   = rd_idx_r;
            pred_start_nxt = f_start;
            acc_len_nxt    = acc_len_r + f_len;
          end
        end
        if (scan_end) state_nxt = vffa_pkg::S_MWRITE;
      end
      vffa_pkg::S_MWRITE: begin
        free_vld_nxt = fmask;
        if (fslot_ok) begin
          free_vld_nxt[fslot] = 1'b1;
          free_we             = 1'b1;
          free_waddr          = fslot;
          free_wdata          = {acc_len_r, pred_fnd_r ? pred_start_r : addr_r};
          if (fslot == '0) free0_init_nxt = 1'b0;
        end
        live_vld_nxt[hit_idx_r] = 1'b0;
        count_nxt               = count_r - hit_len_r;
        res_gr_nxt              = hit_len_r;
        state_nxt               = vffa_pkg::S_DONE;
      end
      vffa_pkg::S_CSCAN: begin
        if (rd_vld_r && live_vld_r[rd_idx_r[LI-1:0]] && addr_r >= l_start &&
            {1'b0, off} <= l_len && rlen_r <= (l_len - {1'b0, off})) begin
          own_nxt = 1'b1;
        end
        if (scan_end) begin
          res_status_nxt = own_r ? vffa_pkg::STAT_OK : vffa_pkg::STAT_NOTOWNED;
          state_nxt      = vffa_pkg::S_DONE;
        end
      end
      vffa_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = vffa_pkg::OUT_DATA_W'({count_r, res_gr_r, res_addr_r, res_status_r});
          state_nxt     = vffa_pkg::S_IDLE;
        end
      end
      default: state_nxt = vffa_pkg::S_IDLE;
    endcase

    if (cfg_we) begin
      unique case (vffa_pkg::reg_idx_t'(cfg_index))
        vffa_pkg::REG_TOTAL_SIZE: begin
          ts_nxt          = ts_clamp;
          free_vld_nxt    = '0;
          free_vld_nxt[0] = (ts_clamp != '0);
          free0_init_nxt  = 1'b1;
          live_vld_nxt    = '0;
          count_nxt       = '0;
        end
        vffa_pkg::REG_ALIGNMENT: align_nxt = cfg_wdata[GW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= vffa_pkg::S_IDLE;
      ts_r         <= vffa_pkg::TOTAL_RESET;
      align_r      <= vffa_pkg::ALIGN_RESET;
      free_vld_r   <= vffa_pkg::FREE_ENTRIES'(1);
      live_vld_r   <= '0;
      free0_init_r <= 1'b1;
      count_r      <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ts_r         <= ts_nxt;
      align_r      <= align_nxt;
      free_vld_r   <= free_vld_nxt;
      live_vld_r   <= live_vld_nxt;
      free0_init_r <= free0_init_nxt;
      count_r      <= count_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    addr_r       <= addr_nxt;
    rlen_r       <= rlen_nxt;
    req_r        <= req_nxt;
    dq_r         <= dq_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    need_r       <= need_nxt;
    slot_r       <= slot_nxt;
    scan_r       <= scan_nxt;
    rd_idx_r     <= rd_idx_nxt;
    best_fnd_r   <= best_fnd_nxt;
    best_idx_r   <= best_idx_nxt;
    best_start_r <= best_start_nxt;
    best_len_r   <= best_len_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_len_r    <= hit_len_nxt;
    succ_fnd_r   <= succ_fnd_nxt;
    succ_idx_r   <= succ_idx_nxt;
    pred_fnd_r   <= pred_fnd_nxt;
    pred_idx_r   <= pred_idx_nxt;
    pred_start_r <= pred_start_nxt;
    acc_len_r    <= acc_len_nxt;
    own_r        <= own_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_gr_r     <= res_gr_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

// ===== src/vffa_ram.sv =====
module vffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/vffa_checker.sv =====
`include "vram_first_fit_allocator_defines.svh"

module vffa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [vffa_pkg::OUT_DATA_W-1:0] out_tdata
);

  `VFFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `VFFA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `VFFA_ASSERT_SAME(a_fail_zero, clk, rst_n, out_tvalid && out_tdata[2:0] != vffa_pkg::STAT_OK, out_tdata[83:3] == '0)

endmodule

bind vram_first_fit_allocator vffa_checker u_vffa_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ===== test/vram_first_fit_allocator_tb.sv =====
`timescale 1ns / 1ps

module vram_first_fit_allocator_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [vffa_pkg::LEN_BITS-1:0]  live_total;
    logic [vffa_pkg::LEN_BITS-1:0]  granted_bytes;
    logic [vffa_pkg::ADDR_BITS-1:0] result_address;
    vffa_pkg::status_t              status;
  } alloc_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [vffa_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [vffa_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_we = 1'b0;
  logic [vffa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [vffa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  vram_first_fit_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the allocator tables.
  logic [vffa_pkg::LEN_BITS-1:0]   shadow_total;
  logic [vffa_pkg::ALIGN_BITS-1:0] shadow_align;
  logic [vffa_pkg::ADDR_BITS-1:0]  free_base [vffa_pkg::FREE_ENTRIES];
  logic [vffa_pkg::LEN_BITS-1:0]   free_len  [vffa_pkg::FREE_ENTRIES];
  logic                            free_used [vffa_pkg::FREE_ENTRIES];
  logic [vffa_pkg::ADDR_BITS-1:0]  live_base [vffa_pkg::LIVE_ENTRIES];
  logic [vffa_pkg::LEN_BITS-1:0]   live_len  [vffa_pkg::LIVE_ENTRIES];
  logic                            live_used [vffa_pkg::LIVE_ENTRIES];
  logic [vffa_pkg::LEN_BITS-1:0]   live_bytes;

  alloc_result_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int settings_used = 0;
  int status_seen [6];
  bit no_idle = 1'b0;
  int hold_left = 0;
  int recv_gap = 0;
  int quiet_cycles = 0;

  function automatic void clear_tables();
    bit [63:0] sz;
    sz = (shadow_total > vffa_pkg::TOTAL_CAP) ? vffa_pkg::TOTAL_CAP : shadow_total;
    for (int i = 0; i < vffa_pkg::FREE_ENTRIES; i++) begin
      free_base[i] = '0; free_len[i] = '0; free_used[i] = 1'b0;
    end
    for (int i = 0; i < vffa_pkg::LIVE_ENTRIES; i++) begin
      live_base[i] = '0; live_len[i] = '0; live_used[i] = 1'b0;
    end
    live_bytes = '0;
    if (sz != 0) begin
      free_len[0] = sz[vffa_pkg::LEN_BITS-1:0];
      free_used[0] = 1'b1;
    end
  endfunction

  function automatic void return_extent(bit [63:0] start, bit [63:0] len);
    bit [63:0] stop;
    int slot;
    stop = start + len;
    slot = -1;
    for (int i = 0; i < vffa_pkg::FREE_ENTRIES; i++) begin
      if (free_used[i] && 64'(free_base[i]) == stop) begin
        len += free_len[i];
        free_used[i] = 1'b0;
        break;
      end
    end
    for (int i = 0; i < vffa_pkg::FREE_ENTRIES; i++) begin
      if (free_used[i] && 64'(free_base[i]) < start &&
          64'(free_base[i]) + 64'(free_len[i]) == start) begin
        start = free_base[i];
        len += free_len[i];
        free_used[i] = 1'b0;
        break;
      end
    end
    for (int i = 0; i < vffa_pkg::FREE_ENTRIES; i++)
      if (!free_used[i]) begin
        slot = i;
        break;
      end
    if (slot >= 0) begin
      free_base[slot] = start[vffa_pkg::ADDR_BITS-1:0];
      free_len[slot] = len[vffa_pkg::LEN_BITS-1:0];
      free_used[slot] = 1'b1;
    end
  endfunction

  function automatic alloc_result_t predict_allocator(vffa_pkg::func_t fn, bit [63:0] req,
                                                      bit [63:0] addr, bit [63:0] rlen);
    alloc_result_t r;
    bit [63:0] gran, need, off, sz;
    int slot, fit;
    r = '0;
    r.status = vffa_pkg::STAT_OK;
    case (fn)
      vffa_pkg::FN_ALLOC: begin
        gran = (shadow_align == 0) ? 64'd1 : 64'(shadow_align);
        slot = -1;
        fit = -1;
        for (int i = 0; i < vffa_pkg::LIVE_ENTRIES; i++)
          if (!live_used[i]) begin
            slot = i;
            break;
          end
        need = (req + gran - 1) / gran * gran;
        for (int i = 0; i < vffa_pkg::FREE_ENTRIES; i++)
          if (free_used[i] && 64'(free_len[i]) >= need &&
              (fit < 0 || free_base[i] < free_base[fit])) fit = i;
        if (req == 0) r.status = vffa_pkg::STAT_ZERO;
        else if (slot < 0) r.status = vffa_pkg::STAT_FULL;
        else if (fit < 0) r.status = vffa_pkg::STAT_NOFIT;
        else begin
          r.result_address = free_base[fit];
          r.granted_bytes = need[vffa_pkg::LEN_BITS-1:0];
          live_base[slot] = free_base[fit];
          live_len[slot] = need[vffa_pkg::LEN_BITS-1:0];
          live_used[slot] = 1'b1;
          live_bytes += need[vffa_pkg::LEN_BITS-1:0];
          if (64'(free_len[fit]) == need) free_used[fit] = 1'b0;
          else begin
            free_base[fit] = free_base[fit] + need[vffa_pkg::ADDR_BITS-1:0];
            free_len[fit] = free_len[fit] - need[vffa_pkg::LEN_BITS-1:0];
          end
        end
      end
      vffa_pkg::FN_FREE: begin
        r.status = vffa_pkg::STAT_NOTLIVE;
        for (int i = 0; i < vffa_pkg::LIVE_ENTRIES; i++) begin
          if (live_used[i] && 64'(live_base[i]) == addr) begin
            live_used[i] = 1'b0;
            live_bytes -= live_len[i];
            return_extent(addr, live_len[i]);
            r.granted_bytes = live_len[i];
            r.status = vffa_pkg::STAT_OK;
            break;
          end
        end
      end
      vffa_pkg::FN_CHECK: begin
        r.status = vffa_pkg::STAT_NOTOWNED;
        for (int i = 0; i < vffa_pkg::LIVE_ENTRIES; i++) begin
          if (live_used[i] && addr >= 64'(live_base[i])) begin
            off = addr - 64'(live_base[i]);
            sz = live_len[i];
            if (off <= sz && rlen <= sz - off) begin
              r.status = vffa_pkg::STAT_OK;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.live_total = live_bytes;
    return r;
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic int pick_live();
    int idx[$];
    for (int i = 0; i < vffa_pkg::LIVE_ENTRIES; i++)
      if (live_used[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(0, idx.size() - 1)];
  endfunction

  task automatic send_request(vffa_pkg::func_t fn, bit [63:0] req, bit [63:0] addr,
                              bit [63:0] rlen);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, rlen[vffa_pkg::LEN_BITS-1:0], addr[vffa_pkg::ADDR_BITS-1:0],
                 req[vffa_pkg::ADDR_BITS-1:0], fn};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_allocator(fn, req[vffa_pkg::ADDR_BITS-1:0],
                                                addr[vffa_pkg::ADDR_BITS-1:0],
                                                rlen[vffa_pkg::LEN_BITS-1:0]));
    items_sent++;
  endtask

  task automatic drain_results();
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_register(vffa_pkg::reg_idx_t idx, bit [63:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[vffa_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == vffa_pkg::REG_TOTAL_SIZE) begin
      shadow_total = value[vffa_pkg::LEN_BITS-1:0];
      clear_tables();
    end else begin
      shadow_align = value[vffa_pkg::ALIGN_BITS-1:0];
    end
    settings_used++;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (in_tvalid && in_tready || out_tvalid && out_tready) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout at %0t after %0d idle cycles", $time, quiet_cycles);
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[vffa_pkg::OUT_RAW_W-1:0];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.status <= vffa_pkg::STAT_NOTOWNED) status_seen[want.status]++;
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.result_address !== want.result_address) begin
          $display("%0t: result_address expected %h actual %h", $time,
                   want.result_address, got.result_address);
          errors++;
        end
        if (got.granted_bytes !== want.granted_bytes) begin
          $display("%0t: granted_bytes expected %h actual %h", $time,
                   want.granted_bytes, got.granted_bytes);
          errors++;
        end
        if (got.live_total !== want.live_total) begin
          $display("%0t: live_total expected %h actual %h", $time,
                   want.live_total, got.live_total);
          errors++;
        end
      end
    end
  end

  // Receiver: a long hold-off wins over the per-item gap.
  always @(posedge clk) begin
    int gap;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (out_tvalid && out_tready) begin
      gap = draw_gap();
      recv_gap <= gap;
      out_tready <= (gap == 0);
    end else if (recv_gap > 0) begin
      out_tready <= (recv_gap == 1);
      recv_gap <= recv_gap - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_directed();
    send_request(vffa_pkg::FN_ALLOC, 0, 0, 0);
    send_request(vffa_pkg::FN_ALLOC, 1, 0, 0);
    send_request(vffa_pkg::FN_ALLOC, 300, 0, 0);
    send_request(vffa_pkg::FN_ALLOC, 64'hFF_FFFF_FFFF, 0, 0);
    send_request(vffa_pkg::FN_CHECK, 0, 0, 256);
    send_request(vffa_pkg::FN_CHECK, 0, 256, 0);
    send_request(vffa_pkg::FN_CHECK, 0, 0, 257);
    send_request(vffa_pkg::FN_CHECK, 0, 300, 468);
    send_request(vffa_pkg::FN_CHECK, 0, 64'hFF_FFFF_FFFF, 64'h1FF_FFFF_FFFF);
    send_request(vffa_pkg::FN_FREE, 0, 5, 0);
    send_request(vffa_pkg::FN_FREE, 0, 0, 0);
    send_request(vffa_pkg::FN_ALLOC, 256, 0, 0);
    send_request(vffa_pkg::FN_FREE, 0, 256, 0);
    send_request(vffa_pkg::FN_FREE, 0, 0, 0);
    send_request(vffa_pkg::FN_NONE, 64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF, 64'h1FF_FFFF_FFFF);
    send_request(vffa_pkg::FN_ALLOC, 268435456, 0, 0);
    send_request(vffa_pkg::FN_ALLOC, 1, 0, 0);
    send_request(vffa_pkg::FN_CHECK, 0, 0, 268435456);
    send_request(vffa_pkg::FN_FREE, 0, 0, 0);
  endtask

  task automatic test_register_extremes();
    write_register(vffa_pkg::REG_TOTAL_SIZE, 0);
    send_request(vffa_pkg::FN_ALLOC, 1, 0, 0);
    write_register(vffa_pkg::REG_TOTAL_SIZE, 64'h1FF_FFFF_FFFF);
    write_register(vffa_pkg::REG_ALIGNMENT, 0);
    send_request(vffa_pkg::FN_ALLOC, 64'hFF_FFFF_FFFF, 0, 0);
    send_request(vffa_pkg::FN_ALLOC, 1, 0, 0);
    send_request(vffa_pkg::FN_CHECK, 0, 64'hFF_FFFF_FFFF, 1);
    write_register(vffa_pkg::REG_ALIGNMENT, 64'h1FFFF);
    send_request(vffa_pkg::FN_ALLOC, 5, 0, 0);
    write_register(vffa_pkg::REG_TOTAL_SIZE, 1);
    write_register(vffa_pkg::REG_ALIGNMENT, 1);
    send_request(vffa_pkg::FN_ALLOC, 1, 0, 0);
    send_request(vffa_pkg::FN_ALLOC, 1, 0, 0);
    send_request(vffa_pkg::FN_FREE, 0, 0, 0);
  endtask

  task automatic test_table_full();
    int order[$];
    write_register(vffa_pkg::REG_TOTAL_SIZE, 64'h10_0000);
    write_register(vffa_pkg::REG_ALIGNMENT, 1);
    repeat (vffa_pkg::LIVE_ENTRIES + 1) send_request(vffa_pkg::FN_ALLOC, 16, 0, 0);
    send_request(vffa_pkg::FN_ALLOC, 0, 0, 0);
    for (int i = 0; i < vffa_pkg::LIVE_ENTRIES; i++) order.push_back(i * 16);
    order.shuffle();
    foreach (order[i]) send_request(vffa_pkg::FN_FREE, 0, order[i], 0);
    send_request(vffa_pkg::FN_ALLOC, 64'h10_0000, 0, 0);
  endtask

  task automatic test_backpressure();
    hold_left = 1500;
    no_idle = 1'b1;
    repeat (20) send_request(vffa_pkg::FN_ALLOC, $urandom_range(1, 4096), 0, 0);
    no_idle = 1'b0;
  endtask

  task automatic test_random(bit [63:0] total, bit [63:0] align, int count);
    bit [63:0] lim, off, span;
    int pick, kind;
    write_register(vffa_pkg::REG_TOTAL_SIZE, total);
    write_register(vffa_pkg::REG_ALIGNMENT, align);
    lim = (total > vffa_pkg::TOTAL_CAP) ? vffa_pkg::TOTAL_CAP : total;
    lim = (lim / 24 == 0) ? 64'd1 : lim / 24;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 50) no_idle = ~no_idle;
      kind = $urandom_range(0, 99);
      pick = pick_live();
      if (kind < 40 || pick < 0) begin
        send_request(vffa_pkg::FN_ALLOC, rand64() % lim + 1, 0, 0);
      end else if (kind < 70) begin
        send_request(vffa_pkg::FN_FREE, 0, live_base[pick], 0);
      end else if (kind < 88) begin
        span = live_len[pick];
        off = rand64() % (span + 1);
        send_request(vffa_pkg::FN_CHECK, 0, 64'(live_base[pick]) + off,
                     rand64() % (span - off + 2));
      end else begin
        send_request(vffa_pkg::func_t'($urandom_range(0, 3)), rand64(), rand64(), rand64());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    shadow_total = vffa_pkg::TOTAL_RESET;
    shadow_align = vffa_pkg::ALIGN_RESET;
    clear_tables();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_table_full();
    write_register(vffa_pkg::REG_TOTAL_SIZE, vffa_pkg::TOTAL_RESET);
    test_backpressure();
    test_random(64'd268435456, 256, 265);
    test_random(64'd4096, 1, 265);
    test_random(64'h100_0000_0000, 65536, 265);
    test_random(rand64() % 64'h1FF_FFFF_FFFF + 1, $urandom_range(0, 131071), 265);
    test_random(64'h1FF_FFFF_FFFF, 0, 265);
    drain_results();
    $display("Sent %0d items over %0d register settings.", items_sent, settings_used);
    $display("Results by status ok/zero/nofit/full/notlive/notowned: %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
